// ===== rtl/dlsc_pkg.sv =====
package dlsc_pkg;

  typedef enum logic [3:0] {
    POS_FB0 = 4'd1,
    POS_FN  = 4'd2,
    POS_FD  = 4'd3,
    POS_FM  = 4'd4,
    POS_FP  = 4'd5,
    POS_FPP = 4'd6,
    POS_BN  = 4'd7,
    POS_BD  = 4'd8,
    POS_BP  = 4'd9
  } pos_t;

  typedef enum logic [1:0] {
    OP_POSITION = 2'd0,
    OP_TICK     = 2'd1,
    OP_LOAD     = 2'd2
  } op_t;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 16;

  localparam logic [CfgIndexWidth-1:0] REG_FN_FAST_CURRENT   = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_FM_CURRENT_LIMIT  = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_FPP_CURRENT_LIMIT = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_BP_FAST_CURRENT   = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_BP_SLOW_CURRENT   = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_BN_FAST_CURRENT   = 3'd5;
  localparam logic [CfgIndexWidth-1:0] REG_STEP_MAXIMUM      = 3'd6;
  localparam logic [CfgIndexWidth-1:0] REG_STEP_MINIMUM      = 3'd7;

  typedef struct packed {
    logic [15:0]        fn_fast_current;
    logic [15:0]        fm_current_limit;
    logic [15:0]        fpp_current_limit;
    logic [15:0]        bp_fast_current;
    logic [15:0]        bp_slow_current;
    logic [15:0]        bn_fast_current;
    logic [6:0]         step_maximum;
    logic signed [7:0]  step_minimum;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    fn_fast_current:   16'd1380,
    fm_current_limit:  16'd1650,
    fpp_current_limit: 16'd2100,
    bp_fast_current:   16'd1500,
    bp_slow_current:   16'd1600,
    bn_fast_current:   16'd1300,
    step_maximum:      7'd28,
    step_minimum:      -8'sd18
  };

endpackage

// ===== rtl/dlsc_cfg.sv =====
module dlsc_cfg
  import dlsc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  output cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FN_FAST_CURRENT:   cfg.fn_fast_current   <= cfg_data;
        REG_FM_CURRENT_LIMIT:  cfg.fm_current_limit  <= cfg_data;
        REG_FPP_CURRENT_LIMIT: cfg.fpp_current_limit <= cfg_data;
        REG_BP_FAST_CURRENT:   cfg.bp_fast_current   <= cfg_data;
        REG_BP_SLOW_CURRENT:   cfg.bp_slow_current   <= cfg_data;
        REG_BN_FAST_CURRENT:   cfg.bn_fast_current   <= cfg_data;
        REG_STEP_MAXIMUM:      cfg.step_maximum      <= cfg_data[6:0];
        REG_STEP_MINIMUM:      cfg.step_minimum      <= $signed(cfg_data[7:0]);
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/dlsc_core.sv =====
module dlsc_core
  import dlsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  op_t               opcode,
  input  logic [3:0]        position_code,
  input  logic [15:0]       motor_current,
  input  logic signed [7:0] step_value,
  input  cfg_t              cfg,
  output pos_t              position_next,
  output logic signed [7:0] step_next
);

  pos_t              position;
  logic signed [7:0] step;
  logic              slow_phase;
  logic              slow_phase_next;

  logic              neighbor;
  logic signed [7:0] tick_step;
  logic              below_max;
  logic              above_min;
  logic              le_fn_fast;
  logic              le_fm_limit;
  logic              ge_fm_limit;
  logic              ge_fpp_limit;
  logic              le_bp_fast;
  logic              le_bp_slow;
  logic              le_bn_fast;

  always_comb begin
    unique case (position)
      POS_FB0: neighbor = (position_code == POS_FN)  || (position_code == POS_BN);
      POS_FN:  neighbor = (position_code == POS_FB0) || (position_code == POS_FD);
      POS_FD:  neighbor = (position_code == POS_FN)  || (position_code == POS_FM);
      POS_FM:  neighbor = (position_code == POS_FD)  || (position_code == POS_FP);
      POS_FP:  neighbor = (position_code == POS_FM)  || (position_code == POS_FPP);
      POS_FPP: neighbor = (position_code == POS_FP);
      POS_BN:  neighbor = (position_code == POS_FB0) || (position_code == POS_BD);
      POS_BD:  neighbor = (position_code == POS_BN)  || (position_code == POS_BP);
      POS_BP:  neighbor = (position_code == POS_BD);
      default: neighbor = 1'b0;
    endcase
  end

  assign below_max    = step < $signed({1'b0, cfg.step_maximum});
  assign above_min    = step > cfg.step_minimum;
  assign le_fn_fast   = motor_current <= cfg.fn_fast_current;
  assign le_fm_limit  = motor_current <= cfg.fm_current_limit;
  assign ge_fm_limit  = motor_current >= cfg.fm_current_limit;
  assign ge_fpp_limit = motor_current >= cfg.fpp_current_limit;
  assign le_bp_fast   = motor_current <= cfg.bp_fast_current;
  assign le_bp_slow   = motor_current <= cfg.bp_slow_current;
  assign le_bn_fast   = motor_current <= cfg.bn_fast_current;

  always_comb begin
    tick_step = step;
    unique case (position)
      POS_FB0: tick_step = '0;
      POS_FN: begin
        if (step > 8'sd0 && (le_fn_fast || slow_phase)) tick_step = step - 8'sd1;
      end
      POS_FM: begin
        if (below_max && le_fm_limit && slow_phase) tick_step = step + 8'sd1;
      end
      POS_FP: begin
        if (below_max && (le_fn_fast || (ge_fm_limit && slow_phase))) begin
          tick_step = step + 8'sd1;
        end
      end
      POS_FPP: begin
        if (below_max && (le_fn_fast || (ge_fpp_limit && slow_phase))) begin
          tick_step = step + 8'sd1;
        end
      end
      POS_BN: begin
        if (step < 8'sd0 && (le_bn_fast || slow_phase)) tick_step = step + 8'sd1;
      end
      POS_BP: begin
        if (above_min && (le_bp_fast || (le_bp_slow && slow_phase))) begin
          tick_step = step - 8'sd1;
        end
      end
      default: tick_step = step;
    endcase
  end

  always_comb begin
    position_next   = position;
    step_next       = step;
    slow_phase_next = slow_phase;
    unique case (opcode)
      OP_POSITION: begin
        if (neighbor) position_next = pos_t'(position_code);
      end
      OP_TICK: begin
        step_next       = tick_step;
        slow_phase_next = ~slow_phase;
      end
      OP_LOAD: step_next = step_value;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= POS_FB0;
      step       <= '0;
      slow_phase <= 1'b0;
    end else if (fire) begin
      position   <= position_next;
      step       <= step_next;
      slow_phase <= slow_phase_next;
    end
  end

endmodule

// ===== rtl/drive_lever_step_controller_unit.sv =====
// Drive/brake lever step controller.
// Channels: the item channel (item_valid, item_stall) carries opcode, position_code,
// motor_current and step_value; the result channel (result_valid, result_stall)
// returns state_number and step_count, one result for every item.
// Configuration: cfg_we writes cfg_data into register cfg_index at a clock edge;
// write only while no item is in flight.
// Path: an accepted item waits in the input register until the result register
// can take it; it is then processed and its result registered at that edge.
// Throughput: one item per cycle unless stalled; lever position, step count and
// tick phase update at the processing edge, so the next item sees them at once.
// Stall: while result_stall holds a result, one more item is taken into the
// input register, then item_stall rises until the result is taken.
// Reset: lever at FB0, step count zero, tick phase even, configuration at its
// default values, both registers empty.
module drive_lever_step_controller_unit
  import dlsc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic [1:0]               opcode,
  input  logic [3:0]               position_code,
  input  logic [15:0]              motor_current,
  input  logic signed [7:0]        step_value,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [3:0]               state_number,
  output logic signed [7:0]        step_count
);

  cfg_t              cfg;
  logic              held;
  op_t               opcode_r;
  logic [3:0]        position_code_r;
  logic [15:0]       motor_current_r;
  logic signed [7:0] step_value_r;
  logic              result_ready;
  logic              fire;
  pos_t              position_next;
  logic signed [7:0] step_next;

  assign result_ready = ~result_valid | ~result_stall;
  assign item_stall   = held & ~result_ready;
  assign fire         = held & result_ready;

  dlsc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dlsc_core u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .opcode        (opcode_r),
    .position_code (position_code_r),
    .motor_current (motor_current_r),
    .step_value    (step_value_r),
    .cfg           (cfg),
    .position_next (position_next),
    .step_next     (step_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!item_stall) begin
      held <= item_valid;
    end
    if (item_valid && !item_stall) begin
      opcode_r        <= op_t'(opcode);
      position_code_r <= position_code;
      motor_current_r <= motor_current;
      step_value_r    <= step_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_ready) begin
      result_valid <= held;
    end
    if (fire) begin
      state_number <= position_next;
      step_count   <= step_next;
    end
  end

endmodule
